// ===== rtl/tvsp_pkg.sv =====
// Shared types and constants for the TV subgradient perturbation block.
// No dependencies.
package tvsp_pkg;

	localparam int VOX_W  = 32;
	localparam int OUT_W  = 31;
	localparam int AIN_W  = 16;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	localparam logic [1:0] CFG_ROWS   = 2'd0;
	localparam logic [1:0] CFG_COLS   = 2'd1;
	localparam logic [1:0] CFG_SLICES = 2'd2;

	localparam logic [63:0] Q30_MAX     = 64'd1073741823;
	localparam logic [63:0] Q30_MIN_MAG = 64'd1073741824;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== rtl/tvsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tvsp_sqrt.sv =====
// Iterative 64-bit integer square root, two radicand bits per cycle.
// Depends on tvsp_pkg.
module tvsp_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        radicand,
	output tvsp_pkg::unit_stat_t stat,
	output logic [31:0]        root
);

	logic        busy_q, done_q;
	logic [63:0] x_q, r_q, bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= 64'd0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== rtl/tvsp_div.sv =====
// Iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on tvsp_pkg.
module tvsp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        dividend,
	input  logic [31:0]        divisor,
	output tvsp_pkg::unit_stat_t stat,
	output logic [63:0]        quotient
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q, den_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, num_q[63]};
	assign fits = trial >= {1'b0, den_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= 32'd0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[62:0], fits};
		end
	end

endmodule

// ===== rtl/tv_subgradient_perturbation.sv =====
// Top level: sequencer, voxel and subgradient stores, shared multiplier.
// Depends on tvsp_pkg, tvsp_ram, tvsp_sqrt, tvsp_div.
//
// Usage: a request is taken when start is high and busy is low. Opcode load
// writes one voxel, compute builds the subgradient and its norm, read
// returns one normalized subgradient value, opcode 3 does nothing. Every
// request gives exactly one result, shown for one cycle with result_valid;
// the receiver cannot stall it. Configuration writes (cfg_valid/cfg_ready,
// always ready) set rows, columns and slices; the user must make them only
// while idle, the block does not enforce it. Load, no-op and reads with
// zero norm or an address beyond the store answer straight from idle;
// other reads do one store read, the divider start, 64 divider steps and
// the finish handoff. Compute clears the store; for each interior voxel
// with a nonzero gradient it does three voxel reads, two products, a
// 32-step root, two 64-step divisions and three store updates (a voxel
// with both differences zero skips all after the reads); then it forms
// the squared sum and its root. Busy is high for all multi-cycle requests.
// Reset returns the registers to 64/64/16, clears the norm, keeps stores.
module tv_subgradient_perturbation #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_SLICES  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [15:0]        voxel_address,
	input  logic signed [31:0] voxel_value,
	output logic               result_valid,
	output logic signed [30:0] perturbation_value,
	output logic               zero_norm,
	output logic               done_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS * MAX_SLICES;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int SW = $clog2(MAX_SLICES + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_MAG,
		ST_MULA, ST_MULB, ST_MULC, ST_SQW, ST_DIVX, ST_DIVXW, ST_DIVYW,
		ST_UPD0, ST_UPD1, ST_UPD2, ST_UPD3, ST_NEXT, ST_SUM, ST_SUMW,
		ST_NRMW, ST_RDQ, ST_RDW
	} state_t;

	state_t state_q;

	logic [6:0] row_q, col_q;
	logic [4:0] slc_q;
	logic [RW-1:0] rows_e;
	logic [CW-1:0] cols_e;
	logic [SW-1:0] slices_e;

	logic [AW-1:0] cnt_q, v_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [SW-1:0] s_q;
	logic [31:0] norm_q;

	logic [31:0] in_addr_w;
	logic        in_range;
	logic [AW-1:0] in_addr, cols_a, v_down, v_right;
	logic last_c, last_r, last_s;

	logic vox_we;
	logic [AW-1:0] vox_raddr;
	logic [31:0] vox_rdata;
	logic sub_we;
	logic [AW-1:0] sub_waddr, sub_raddr;
	logic [31:0] sub_wdata, sub_rdata;

	logic [31:0] here_q, right_q;
	logic [32:0] gx_q, gy_q, ax, bx;
	logic [30:0] a_q, b_q;
	logic negx_q, negy_q, neg_rd_q;
	logic g_zero;
	logic [63:0] prod_q, sq_q, acc_q;
	logic [31:0] mul_a, mul_b;
	logic [31:0] m_q, tx_q, ty_q, term;
	logic [31:0] mag_s2;
	logic rd_v_s1, mag_v_s2, prod_v_s3;

	logic sq_start, div_start;
	logic [63:0] sq_in, div_num, div_quo, q_sat, q_neg;
	logic [31:0] div_den, sq_root;
	tvsp_pkg::unit_stat_t sq_stat, div_stat;
	logic [30:0] rd_value;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		if (row_q < 7'd2) rows_e = RW'(2);
		else if (32'(row_q) > 32'(MAX_ROWS)) rows_e = RW'(MAX_ROWS);
		else rows_e = RW'(row_q);
		if (col_q < 7'd2) cols_e = CW'(2);
		else if (32'(col_q) > 32'(MAX_COLUMNS)) cols_e = CW'(MAX_COLUMNS);
		else cols_e = CW'(col_q);
		if (slc_q < 5'd1) slices_e = SW'(1);
		else if (32'(slc_q) > 32'(MAX_SLICES)) slices_e = SW'(MAX_SLICES);
		else slices_e = SW'(slc_q);
	end

	assign in_addr_w = 32'(voxel_address);
	assign in_range = in_addr_w < 32'(DEPTH);
	assign in_addr = in_addr_w[AW-1:0];
	assign cols_a = AW'(cols_e);
	assign v_down = v_q + cols_a;
	assign v_right = v_q + AW'(1);
	assign last_c = (c_q == cols_e - CW'(2));
	assign last_r = (r_q == rows_e - RW'(2));
	assign last_s = (s_q == slices_e - SW'(1));

	assign ax = gx_q[32] ? (~gx_q + 33'd1) : gx_q;
	assign bx = gy_q[32] ? (~gy_q + 33'd1) : gy_q;
	assign g_zero = (gx_q == 33'd0) && (gy_q == 33'd0);

	// memories
	assign vox_we = (state_q == ST_IDLE) && start && !busy && opcode == tvsp_pkg::OP_LOAD
		&& in_range;

	always_comb begin
		case (state_q)
			ST_RD1:  vox_raddr = v_right;
			ST_RD2:  vox_raddr = v_down;
			default: vox_raddr = v_q;
		endcase
	end

	always_comb begin
		sub_we = 1'b0;
		sub_waddr = v_q;
		sub_wdata = 32'd0;
		sub_raddr = v_q;
		case (state_q)
			ST_IDLE: sub_raddr = in_addr;
			ST_CLR: begin
				sub_we = 1'b1;
				sub_waddr = cnt_q;
			end
			ST_UPD1: begin
				sub_we = 1'b1;
				sub_wdata = sub_rdata - tx_q - ty_q;
				sub_raddr = v_down;
			end
			ST_UPD2: begin
				sub_we = 1'b1;
				sub_waddr = v_down;
				sub_wdata = sub_rdata + ty_q;
				sub_raddr = v_right;
			end
			ST_UPD3: begin
				sub_we = 1'b1;
				sub_waddr = v_right;
				sub_wdata = sub_rdata + tx_q;
			end
			ST_SUM: sub_raddr = cnt_q;
			default: sub_raddr = v_q;
		endcase
	end

	tvsp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vox (
		.clk(clk), .we(vox_we), .waddr(in_addr), .wdata(voxel_value),
		.raddr(vox_raddr), .rdata(vox_rdata)
	);

	tvsp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sub (
		.clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wdata),
		.raddr(sub_raddr), .rdata(sub_rdata)
	);

	// shared arithmetic units
	always_comb begin
		case (state_q)
			ST_MULA: begin
				mul_a = 32'(a_q);
				mul_b = 32'(a_q);
			end
			ST_MULB: begin
				mul_a = 32'(b_q);
				mul_b = 32'(b_q);
			end
			default: begin
				mul_a = mag_s2;
				mul_b = mag_s2;
			end
		endcase
	end

	assign sq_start = (state_q == ST_MULC) ||
		(state_q == ST_SUMW && !rd_v_s1 && !mag_v_s2 && !prod_v_s3);
	assign sq_in = (state_q == ST_MULC) ? (sq_q + prod_q) : acc_q;

	assign div_start = (state_q == ST_DIVX) || (state_q == ST_RDQ) ||
		(state_q == ST_DIVXW && div_stat.done);
	always_comb begin
		case (state_q)
			ST_DIVX:  div_num = {5'd0, a_q, 28'd0};
			ST_DIVXW: div_num = {5'd0, b_q, 28'd0};
			default:  div_num = {10'd0, (sub_rdata[31] ? (~sub_rdata + 32'd1) : sub_rdata), 22'd0};
		endcase
	end
	assign div_den = (state_q == ST_RDQ) ? norm_q : m_q;

	tvsp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.stat(sq_stat), .root(sq_root)
	);

	tvsp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .stat(div_stat), .quotient(div_quo)
	);

	always_comb begin
		if (state_q == ST_DIVXW) term = negx_q ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
		else term = negy_q ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
	end

	always_comb begin
		if (neg_rd_q) begin
			q_sat = (div_quo > tvsp_pkg::Q30_MIN_MAG) ? tvsp_pkg::Q30_MIN_MAG : div_quo;
			q_neg = ~q_sat + 64'd1;
			rd_value = q_neg[30:0];
		end else begin
			q_sat = (div_quo > tvsp_pkg::Q30_MAX) ? tvsp_pkg::Q30_MAX : div_quo;
			q_neg = q_sat;
			rd_value = q_sat[30:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		mag_s2 <= sub_rdata[31] ? (~sub_rdata + 32'd1) : sub_rdata;
		if (prod_v_s3) acc_q <= acc_q + (prod_q >> 16);
		case (state_q)
			ST_RD1: here_q <= vox_rdata;
			ST_RD2: right_q <= vox_rdata;
			ST_RD3: begin
				gx_q <= {right_q[31], right_q} - {here_q[31], here_q};
				gy_q <= {vox_rdata[31], vox_rdata} - {here_q[31], here_q};
			end
			ST_MAG: begin
				negx_q <= gx_q[32];
				negy_q <= gy_q[32];
				if (ax[32] || ax[31] || bx[32] || bx[31]) begin
					a_q <= ax[31:1];
					b_q <= bx[31:1];
				end else begin
					a_q <= ax[30:0];
					b_q <= bx[30:0];
				end
			end
			ST_MULB: sq_q <= prod_q;
			ST_SQW: if (sq_stat.done) m_q <= sq_root;
			ST_DIVXW: if (div_stat.done) tx_q <= term;
			ST_DIVYW: if (div_stat.done) ty_q <= term;
			ST_NEXT: acc_q <= 64'd0;
			ST_RDQ: neg_rd_q <= sub_rdata[31];
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= 7'd64;
			col_q <= 7'd64;
			slc_q <= 5'd16;
			norm_q <= 32'd0;
			cnt_q <= '0;
			v_q <= '0;
			c_q <= '0;
			r_q <= '0;
			s_q <= '0;
			rd_v_s1 <= 1'b0;
			mag_v_s2 <= 1'b0;
			prod_v_s3 <= 1'b0;
			result_valid <= 1'b0;
			perturbation_value <= '0;
			zero_norm <= 1'b0;
			done_res <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rd_v_s1 <= (state_q == ST_SUM);
			mag_v_s2 <= rd_v_s1;
			prod_v_s3 <= mag_v_s2;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tvsp_pkg::CFG_ROWS:   row_q <= cfg_data;
					tvsp_pkg::CFG_COLS:   col_q <= cfg_data;
					tvsp_pkg::CFG_SLICES: slc_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (opcode)
							tvsp_pkg::OP_LOAD: begin
								result_valid <= 1'b1;
								perturbation_value <= '0;
								zero_norm <= 1'b0;
								done_res <= 1'b1;
							end
							tvsp_pkg::OP_COMPUTE: begin
								cnt_q <= '0;
								state_q <= ST_CLR;
							end
							tvsp_pkg::OP_READ: begin
								if (!in_range || norm_q == 32'd0) begin
									result_valid <= 1'b1;
									perturbation_value <= '0;
									zero_norm <= (norm_q == 32'd0);
									done_res <= 1'b1;
								end else begin
									state_q <= ST_RDQ;
								end
							end
							default: begin
								result_valid <= 1'b1;
								perturbation_value <= '0;
								zero_norm <= 1'b0;
								done_res <= 1'b0;
							end
						endcase
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(DEPTH - 1)) begin
						v_q <= '0;
						c_q <= '0;
						r_q <= '0;
						s_q <= '0;
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_MAG;
				ST_MAG: state_q <= g_zero ? ST_NEXT : ST_MULA;
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: state_q <= ST_MULC;
				ST_MULC: state_q <= ST_SQW;
				ST_SQW: if (sq_stat.done) state_q <= ST_DIVX;
				ST_DIVX: state_q <= ST_DIVXW;
				ST_DIVXW: if (div_stat.done) state_q <= ST_DIVYW;
				ST_DIVYW: if (div_stat.done) state_q <= ST_UPD0;
				ST_UPD0: state_q <= ST_UPD1;
				ST_UPD1: state_q <= ST_UPD2;
				ST_UPD2: state_q <= ST_UPD3;
				ST_UPD3: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (last_c) begin
						c_q <= '0;
						if (last_r) begin
							r_q <= '0;
							s_q <= s_q + SW'(1);
							v_q <= v_q + cols_a + AW'(2);
						end else begin
							r_q <= r_q + RW'(1);
							v_q <= v_q + AW'(2);
						end
					end else begin
						c_q <= c_q + CW'(1);
						v_q <= v_q + AW'(1);
					end
					if (last_c && last_r && last_s) begin
						cnt_q <= '0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_RD0;
					end
				end
				ST_SUM: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(DEPTH - 1)) state_q <= ST_SUMW;
				end
				ST_SUMW: if (sq_start) state_q <= ST_NRMW;
				ST_NRMW: begin
					if (sq_stat.done) begin
						norm_q <= sq_root;
						result_valid <= 1'b1;
						perturbation_value <= '0;
						zero_norm <= (sq_root == 32'd0);
						done_res <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RDQ: state_q <= ST_RDW;
				ST_RDW: begin
					if (div_stat.done) begin
						result_valid <= 1'b1;
						perturbation_value <= rd_value;
						zero_norm <= 1'b0;
						done_res <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !sq_stat.busy && !div_stat.busy)
		else $error("arithmetic unit running while idle");

	a_nop_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !done_res |-> perturbation_value == 31'd0 && !zero_norm)
		else $error("no-op result carries data");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy) || $past(busy))
		else $error("result without a request");

	a_zero_norm_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_norm |-> perturbation_value == 31'd0)
		else $error("nonzero value with zero norm");

endmodule
